@@ rtl/core/tsati_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsati_pkg
// Shared types and constants of the two-stage active tension integrator.
// ----------------------------------------------------------------------------
package tsati_pkg;

    localparam int VOLT_W    = 16;
    localparam int WIDTH_W   = 16;
    localparam int RATE_W    = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_GAUSS_WIDTH       = 2'd0;
    localparam cfg_idx_t REG_TENSION_RATE      = 2'd1;
    localparam cfg_idx_t REG_VOLTAGE_THRESHOLD = 2'd2;
    localparam cfg_idx_t REG_TENSION_THRESHOLD = 2'd3;

    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
    localparam logic [31:0] LN2_Q30   = 32'd744261118;
    localparam logic [63:0] INVSQ_Q24 = 64'd6694838;
    localparam logic [31:0] STEP_Q20  = 32'd52429;
    localparam logic [63:0] SLOW_G64  = (64'd429497 * 64'd52429) >> 16;
    localparam logic [31:0] SLOW_G    = SLOW_G64[31:0];
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam int          X_BITS    = 22;

    // ceil(2^33 / k); exact floor(p / k) for p < 2^30 as (p * m) >> 33
    function automatic logic [31:0] recip(input logic [2:0] k);
        logic [31:0] m;
        begin
            case (k)
                3'd3:    m = 32'd2863311531;
                3'd5:    m = 32'd1717986919;
                3'd6:    m = 32'd1431655766;
                3'd7:    m = 32'd1227133514;
                default: m = 32'd0;
            endcase
            return m;
        end
    endfunction

endpackage

@@ rtl/core/tsati_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsati_in_if / tsati_out_if
// Valid/ready channels for voltage samples and tension results.
// ----------------------------------------------------------------------------
interface tsati_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] voltage;

    modport source (output valid, output voltage, input ready);
    modport sink (input valid, input voltage, output ready);
endinterface

interface tsati_out_if #(
    parameter int TW = 23
);
    logic          valid;
    logic          ready;
    logic [TW-1:0] fast_tension;
    logic [TW-1:0] slow_tension;

    modport source (output valid, output fast_tension, output slow_tension, input ready);
    modport sink (input valid, input fast_tension, input slow_tension, output ready);
endinterface

@@ rtl/core/two_stage_active_tension_integrator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stage_active_tension_integrator
// Gaussian voltage drive feeding two chained Euler tension stages, computed
// on one shared 32x32 multiplier and one restoring divider.
// Each beat runs two divider passes and the 7-step exp series; zero drive
// skips to the Euler steps when the exponent quotient overflows, or when
// the exponent is too large after the division.
// Throughput: one beat at a time; next beat taken once the result is stored.
// Reset: async active low; tensions clear, config returns to defaults.
// ----------------------------------------------------------------------------
module two_stage_active_tension_integrator #(
    parameter int TENSION_FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tsati_in_if.sink                         sample,
    tsati_out_if.source                      result,
    input  logic                             cfg_wr_en,
    input  tsati_pkg::cfg_idx_t              cfg_index,
    input  logic [((7 + TENSION_FRAC_BITS) > 16 ? (7 + TENSION_FRAC_BITS) : 16)-1:0] cfg_data
);
    import tsati_pkg::*;

    localparam int TBITS = 7 + TENSION_FRAC_BITS;
    localparam int DW    = (TBITS > X_BITS) ? TBITS : X_BITS;
    localparam int RW    = 34;
    localparam int CNT_W = $clog2(DW + 1);
    localparam logic [63:0] A_DVD = (INVSQ_Q24 << TENSION_FRAC_BITS) >> 16;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SQV   = 5'd1;
    localparam logic [4:0] ST_SQS   = 5'd2;
    localparam logic [4:0] ST_XINIT = 5'd3;
    localparam logic [4:0] ST_DIV   = 5'd4;
    localparam logic [4:0] ST_Y     = 5'd5;
    localparam logic [4:0] ST_Z     = 5'd6;
    localparam logic [4:0] ST_ZL    = 5'd7;
    localparam logic [4:0] ST_HP    = 5'd8;
    localparam logic [4:0] ST_HQ    = 5'd9;
    localparam logic [4:0] ST_HT    = 5'd10;
    localparam logic [4:0] ST_AINIT = 5'd11;
    localparam logic [4:0] ST_DRV   = 5'd12;
    localparam logic [4:0] ST_SH    = 5'd13;
    localparam logic [4:0] ST_G     = 5'd14;
    localparam logic [4:0] ST_E1M   = 5'd15;
    localparam logic [4:0] ST_E1    = 5'd16;
    localparam logic [4:0] ST_E2M   = 5'd17;
    localparam logic [4:0] ST_E2    = 5'd18;
    localparam logic [4:0] ST_DONE  = 5'd19;

    logic [4:0]             state_reg, state_next;
    logic [WIDTH_W-1:0]     gw_reg;
    logic [RATE_W-1:0]      rate_reg;
    logic signed [VOLT_W-1:0] vth_reg;
    logic [TBITS-1:0]       tth_reg;
    logic [TBITS-1:0]       s1_reg, s2_reg;
    logic                   out_valid_reg;
    logic [TBITS-1:0]       out_fast_reg, out_slow_reg;

    logic signed [VOLT_W-1:0] v_reg;
    logic [63:0]            prod_reg;
    logic [31:0]            adsq_reg;
    logic [RW-1:0]          rem_reg;
    logic [32:0]            dsr_reg;
    logic [DW-1:0]          dvd_reg, quo_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   phase_reg;
    logic [5:0]             n_reg;
    logic [29:0]            z_reg, p_reg;
    logic [30:0]            t_reg;
    logic [2:0]             k_reg;
    logic [TBITS-1:0]       drive_reg;
    logic [31:0]            g_reg;
    logic                   up_reg;

    logic [31:0]            ma, mb;
    logic [WIDTH_W-1:0]     s_eff;
    logic signed [16:0]     d;
    logic [16:0]            ad17;
    logic [RW:0]            trial;
    logic [29:0]            q;
    logic [TBITS-1:0]       cur, tgt, diff, delta, upd;
    logic                   slow;
    logic                   accept;
    logic                   load_out;

    assign accept   = sample.valid && sample.ready;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
    assign s_eff    = (gw_reg == '0) ? WIDTH_W'(1) : gw_reg;
    assign d        = {v_reg[VOLT_W-1], v_reg} - 17'sd256;
    assign ad17     = d[16] ? 17'(-d) : 17'(d);
    assign trial    = {1'b0, rem_reg[RW-2:0], dvd_reg[DW-1]} - (RW+1)'(dsr_reg);

    assign cur   = (state_reg == ST_E2M || state_reg == ST_E2) ? s2_reg : s1_reg;
    assign tgt   = (state_reg == ST_E2M || state_reg == ST_E2) ? s1_reg : drive_reg;
    assign diff  = (tgt >= cur) ? tgt - cur : cur - tgt;
    assign delta = TBITS'(prod_reg[63:36]);
    assign upd   = up_reg ? cur + delta : cur - delta;
    assign slow  = (v_reg > vth_reg) && (upd < tth_reg);

    always_comb
    begin
        case (k_reg)
            3'd1:    q = p_reg;
            3'd2:    q = p_reg >> 1;
            3'd4:    q = p_reg >> 2;
            default: q = prod_reg[62:33];
        endcase
    end

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            ST_SQV:
            begin
                ma = 32'(ad17[15:0]);
                mb = 32'(ad17[15:0]);
            end
            ST_SQS:
            begin
                ma = 32'(s_eff);
                mb = 32'(s_eff);
            end
            ST_Y:
            begin
                ma = 32'(quo_reg[X_BITS-1:0]);
                mb = LOG2E_Q30;
            end
            ST_Z:
            begin
                ma = {2'b0, prod_reg[45:16]};
                mb = LN2_Q30;
            end
            ST_HP:
            begin
                ma = {2'b0, z_reg};
                mb = {1'b0, t_reg};
            end
            ST_HQ:
            begin
                ma = {2'b0, prod_reg[59:30]};
                mb = recip(k_reg);
            end
            ST_DRV:
            begin
                ma = 32'(quo_reg[TBITS-1:0]);
                mb = {1'b0, t_reg};
            end
            ST_G:
            begin
                ma = 32'(rate_reg);
                mb = STEP_Q20;
            end
            ST_E1M:
            begin
                ma = 32'(diff);
                mb = prod_reg[31:0];
            end
            ST_E2M:
            begin
                ma = 32'(diff);
                mb = g_reg;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_SQV;
            ST_SQV:   state_next = ST_SQS;
            ST_SQS:   state_next = ST_XINIT;
            ST_XINIT:
            begin
                if (RW'(adsq_reg >> 6) >= RW'({prod_reg[31:0], 1'b0}))
                    state_next = ST_G;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                    state_next = phase_reg ? ST_DRV : ST_Y;
            end
            ST_Y:     state_next = ST_Z;
            ST_Z:     state_next = (prod_reg[63:46] >= 18'd33) ? ST_G : ST_ZL;
            ST_ZL:    state_next = ST_HP;
            ST_HP:    state_next = ST_HQ;
            ST_HQ:    state_next = ST_HT;
            ST_HT:    state_next = (k_reg == 3'd1) ? ST_AINIT : ST_HP;
            ST_AINIT: state_next = ST_DIV;
            ST_DRV:   state_next = ST_SH;
            ST_SH:    state_next = ST_G;
            ST_G:     state_next = ST_E1M;
            ST_E1M:   state_next = ST_E1;
            ST_E1:    state_next = ST_E2M;
            ST_E2M:   state_next = ST_E2;
            ST_E2:    state_next = ST_DONE;
            ST_DONE:  if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gw_reg        <= WIDTH_W'(256);
            rate_reg      <= RATE_W'(65535);
            vth_reg       <= '0;
            tth_reg       <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_GAUSS_WIDTH:       gw_reg   <= cfg_data[WIDTH_W-1:0];
                    REG_TENSION_RATE:      rate_reg <= cfg_data[RATE_W-1:0];
                    REG_VOLTAGE_THRESHOLD: vth_reg  <= cfg_data[VOLT_W-1:0];
                    REG_TENSION_THRESHOLD: tth_reg  <= cfg_data[TBITS-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_E1)
                s1_reg <= upd;
            if (state_reg == ST_E2)
                s2_reg <= upd;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(ma) * 64'(mb);
        if (accept)
            v_reg <= sample.voltage;
        if (load_out)
        begin
            out_fast_reg <= s1_reg;
            out_slow_reg <= s2_reg;
        end
        case (state_reg)
            ST_SQS:
                adsq_reg <= prod_reg[31:0];
            ST_XINIT:
            begin
                // zero drive unless the exponent quotient stays under 2^22
                drive_reg <= '0;
                dsr_reg   <= {prod_reg[31:0], 1'b0};
                rem_reg   <= RW'(adsq_reg >> 6);
                dvd_reg   <= DW'({adsq_reg[5:0], 16'b0}) << (DW - X_BITS);
                quo_reg   <= '0;
                cnt_reg   <= CNT_W'(X_BITS);
                phase_reg <= 1'b0;
            end
            ST_DIV:
            begin
                dvd_reg <= dvd_reg << 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (!trial[RW])
                begin
                    rem_reg <= trial[RW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[RW-2:0], dvd_reg[DW-1]};
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
            end
            ST_Z:
            begin
                n_reg     <= prod_reg[51:46];
                drive_reg <= '0;
            end
            ST_ZL:
            begin
                z_reg <= prod_reg[59:30];
                t_reg <= ONE_Q30;
                k_reg <= 3'd7;
            end
            ST_HQ:
                p_reg <= prod_reg[59:30];
            ST_HT:
            begin
                t_reg <= ONE_Q30 - 31'(q);
                k_reg <= k_reg - 3'd1;
            end
            ST_AINIT:
            begin
                rem_reg   <= '0;
                dsr_reg   <= 33'(s_eff);
                dvd_reg   <= DW'(A_DVD[TBITS-1:0]) << (DW - TBITS);
                quo_reg   <= '0;
                cnt_reg   <= CNT_W'(TBITS);
                phase_reg <= 1'b1;
            end
            ST_SH:
                drive_reg <= TBITS'(prod_reg >> (7'd30 + 7'(n_reg)));
            ST_E1M:
            begin
                g_reg  <= prod_reg[31:0];
                up_reg <= (tgt >= cur);
            end
            ST_E1:
                if (slow) g_reg <= SLOW_G;
            ST_E2M:
                up_reg <= (tgt >= cur);
            default: ;
        endcase
    end

    assign sample.ready        = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.fast_tension = out_fast_reg;
    assign result.slow_tension = out_slow_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SQV))
        else $error("accepted beat did not start the sequence");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg != '0))
        else $error("divider entered with zero count");

    a_series_k: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HP || state_reg == ST_HQ || state_reg == ST_HT) |-> (k_reg != 3'd0))
        else $error("series index out of range");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (result.valid && state_reg == ST_IDLE))
        else $error("result not presented after load");
`endif

endmodule

@@ bench/two_stage_active_tension_integrator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stage_active_tension_integrator_test
// Drives voltage samples through the valid/ready channels, with register
// settings changed between phases, and checks every tension pair against a
// fixed-point model of the Gaussian drive and both Euler stages (the first
// directed pair against typed values). Directed samples come first, then
// random ones under varied idling and a long result stall.
// ----------------------------------------------------------------------------
module two_stage_active_tension_integrator_test;
    import tsati_pkg::*;

    localparam int FRAC = 16;
    localparam int TW = 7 + FRAC;
    localparam logic [63:0] TENSION_MAX = (64'd1 << TW) - 64'd1;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] SLOW_RATE32 = 64'd429497;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [TW-1:0] fast;
        logic [TW-1:0] slow;
    } tension_pair_t;

    typedef struct {
        logic signed [15:0] volt;
        bit                 known;
        logic [TW-1:0]      fast;
        logic [TW-1:0]      slow;
    } sample_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    cfg_idx_t cfg_index;
    logic [TW-1:0] cfg_data;

    tsati_in_if sample_if ();
    tsati_out_if #(.TW(TW)) result_if ();

    two_stage_active_tension_integrator #(.TENSION_FRAC_BITS(FRAC)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample_if),
        .result(result_if),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // model copy of registers and stages
    logic [15:0] m_width;
    logic [15:0] m_rate;
    logic signed [15:0] m_vth;
    logic [TW-1:0] m_tth;
    logic [63:0] m_fast;
    logic [63:0] m_slow;

    tension_pair_t pending_q[$];
    int mismatches;
    int failures;
    int cycles;
    int send_idle;
    int recv_idle;
    bit pressure_req;
    bit pressure_done;
    int hold_cnt;

    sample_row_t rows[] = '{
        '{16'sd256, 1'b1, 23'd1307, 23'd65},
        '{-16'sd32768, 1'b0, 23'd0, 23'd0},
        '{16'sd32767, 1'b0, 23'd0, 23'd0},
        '{16'sd0, 1'b0, 23'd0, 23'd0},
        '{16'sd255, 1'b0, 23'd0, 23'd0},
        '{16'sd257, 1'b0, 23'd0, 23'd0},
        '{-16'sd1, 1'b0, 23'd0, 23'd0},
        '{16'sd1, 1'b0, 23'd0, 23'd0},
        '{16'sd512, 1'b0, 23'd0, 23'd0},
        '{16'sh5555, 1'b0, 23'd0, 23'd0},
        '{-16'sh5556, 1'b0, 23'd0, 23'd0},
        '{16'sd2304, 1'b0, 23'd0, 23'd0},
        '{-16'sd1792, 1'b0, 23'd0, 23'd0},
        '{16'sd256, 1'b0, 23'd0, 23'd0}
    };

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] gauss_drive(input int volt);
        logic [63:0] s, mag, x, y, n, f, z, t, amp;
        int d;
        s = (m_width == 16'd0) ? 64'd1 : 64'(m_width);
        d = volt - 256;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        x = ((mag * mag) << 16) / (64'd2 * s * s);
        if (x >= (64'd64 << 16))
            return 64'd0;
        y = (x * 64'(LOG2E_Q30)) >> 16;
        n = y >> 30;
        if (n >= 64'd33)
            return 64'd0;
        f = y & (Q30_ONE - 64'd1);
        z = (f * 64'(LN2_Q30)) >> 30;
        t = Q30_ONE;
        for (int k = 7; k >= 1; k--)
            t = Q30_ONE - ((z * t) >> 30) / 64'(k);
        amp = (INVSQ_Q24 << FRAC) / (s << 16);
        if (amp > TENSION_MAX)
            amp = TENSION_MAX;
        return (amp * t) >> (64'd30 + n);
    endfunction

    function automatic logic [63:0] euler_move(input logic [63:0] stage,
                                               input logic [63:0] target,
                                               input logic [63:0] rate32);
        logic [63:0] g, r, dl;
        g = (rate32 * 64'(STEP_Q20)) >> 16;
        if (target >= stage)
            r = stage + (((target - stage) * g) >> 36);
        else
        begin
            dl = ((stage - target) * g) >> 36;
            r = (dl > stage) ? 64'd0 : stage - dl;
        end
        return (r > TENSION_MAX) ? TENSION_MAX : r;
    endfunction

    function automatic tension_pair_t advance_tensions(input logic signed [15:0] volt);
        tension_pair_t p;
        logic [63:0] rate32;
        rate32 = 64'(m_rate) << 16;
        m_fast = euler_move(m_fast, gauss_drive(int'(volt)), rate32);
        if (volt > m_vth && m_fast < 64'(m_tth))
            rate32 = SLOW_RATE32;
        m_slow = euler_move(m_slow, m_fast, rate32);
        p.fast = m_fast[TW-1:0];
        p.slow = m_slow[TW-1:0];
        return p;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [TW-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_GAUSS_WIDTH:       m_width = value[15:0];
            REG_TENSION_RATE:      m_rate = value[15:0];
            REG_VOLTAGE_THRESHOLD: m_vth = value[15:0];
            REG_TENSION_THRESHOLD: m_tth = value;
            default: ;
        endcase
    endtask

    task automatic send_sample(input logic signed [15:0] volt, input bit known,
                               input tension_pair_t typed);
        tension_pair_t p;
        while ($urandom_range(99) < send_idle)
        begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid <= 1'b1;
        sample_if.voltage <= volt;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
        p = advance_tensions(volt);
        pending_q.push_back(known ? typed : p);
    endtask

    task automatic drain();
        sample_if.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_settings(input int pick);
        logic [15:0] w, r, vt;
        logic [TW-1:0] tt;
        case (pick % 4)
            0: begin w = 16'd1;     r = 16'd65535; vt = 16'h8000; tt = TW'(TENSION_MAX); end
            1: begin w = 16'd65535; r = 16'd0;     vt = 16'h7FFF; tt = '0; end
            2: begin w = 16'd0;     r = 16'($urandom); vt = 16'($urandom);
                     tt = TW'($urandom_range(4000)); end
            default: begin
                w = 16'($urandom_range(4096, 16));
                r = 16'($urandom);
                vt = 16'($urandom_range(1024)) - 16'd256;
                tt = TW'($urandom);
            end
        endcase
        write_reg(REG_GAUSS_WIDTH, TW'(w));
        write_reg(REG_TENSION_RATE, TW'(r));
        write_reg(REG_VOLTAGE_THRESHOLD, TW'(vt));
        write_reg(REG_TENSION_THRESHOLD, tt);
    endtask

    function automatic logic signed [15:0] random_voltage();
        int span, v;
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        span = (m_width == 0 ? 1 : int'(m_width)) * 6;
        if (span > 40000)
            span = 40000;
        v = 256 + int'($urandom_range(2 * span)) - span;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    // long receiver hold, counted in cycles
    always @(posedge clk)
    begin
        if (pressure_req && !pressure_done)
        begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt + 1 >= HOLD_CYCLES)
                pressure_done <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        tension_pair_t exp_p;
        if (result_if.valid && result_if.ready)
        begin
            if (pending_q.size() == 0)
            begin
                failures++;
                $display("unexpected beat: fast %0d slow %0d",
                         result_if.fast_tension, result_if.slow_tension);
            end
            else
            begin
                exp_p = pending_q.pop_front();
                if (exp_p.fast !== result_if.fast_tension
                    || exp_p.slow !== result_if.slow_tension)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: fast exp %0d got %0d, slow exp %0d got %0d",
                                 exp_p.fast, result_if.fast_tension,
                                 exp_p.slow, result_if.slow_tension);
                end
            end
        end
        if (pressure_req && !pressure_done)
            result_if.ready <= 1'b0;
        else
            result_if.ready <= ($urandom_range(99) >= recv_idle);
    end

    initial
    begin
        tension_pair_t typed;
        cycles = 0;
        mismatches = 0;
        failures = 0;
        send_idle = 15;
        recv_idle = 69;
        pressure_req = 1'b0;
        pressure_done = 1'b0;
        hold_cnt = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_GAUSS_WIDTH;
        cfg_data = '0;
        sample_if.valid = 1'b0;
        sample_if.voltage = '0;
        result_if.ready = 1'b0;
        m_width = 16'd256;
        m_rate = 16'd65535;
        m_vth = '0;
        m_tth = '0;
        m_fast = '0;
        m_slow = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            typed.fast = rows[i].fast;
            typed.slow = rows[i].slow;
            send_sample(rows[i].volt, rows[i].known, typed);
        end
        drain();
        // strict threshold compares at their boundaries
        write_reg(REG_TENSION_THRESHOLD, TW'(TENSION_MAX));
        write_reg(REG_VOLTAGE_THRESHOLD, TW'(16'd256));
        send_sample(16'sd256, 1'b0, typed);
        send_sample(16'sd257, 1'b0, typed);
        send_sample(16'sd255, 1'b0, typed);
        drain();
        write_reg(REG_TENSION_THRESHOLD, TW'(m_fast));
        send_sample(16'sd300, 1'b0, typed);
        send_sample(16'sd300, 1'b0, typed);
        drain();

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle = (mode == 0) ? 15 : (mode == 1) ? 69 : 0;
            recv_idle = (mode == 0) ? 69 : (mode == 1) ? 15 : 0;
            for (int ph = 0; ph < 4; ph++)
            begin
                random_settings(ph + $urandom_range(3) * (mode == 2 ? 1 : 0));
                if (mode == 2 && ph == 1)
                    pressure_req = 1'b1;
                for (int i = 0; i < 140; i++)
                    send_sample(random_voltage(), 1'b0, typed);
                drain();
            end
        end

        if (pending_q.size() != 0)
            failures++;
        if (mismatches == 0 && failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
